@@ src/typed_fnv1a64_hasher_top_assert.svh @@
// assertion macros used by the checker in fnv64_chk.sv
`ifndef TYPED_FNV1A64_HASHER_TOP_ASSERT_SVH
`define TYPED_FNV1A64_HASHER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define FNV64_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FNV64_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/fnv64_pkg.sv @@
`timescale 1ns / 1ps

package fnv64_pkg;

    // kind codes of an input item
    localparam logic [2:0] KIND_U8  = 3'd0;
    localparam logic [2:0] KIND_U16 = 3'd1;
    localparam logic [2:0] KIND_U32 = 3'd2;
    localparam logic [2:0] KIND_U64 = 3'd3;
    localparam logic [2:0] KIND_F32 = 3'd4;
    localparam logic [2:0] KIND_F64 = 3'd5;

    // fnv-1a 64 constants; prime is 2^40 + 0x1b3
    localparam logic [63:0] FNV_BASIS       = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;
    localparam int          FNV_PRIME_SHIFT = 40;

    // float negative zero patterns
    localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;
    localparam logic [63:0] F64_NEG_ZERO = 64'h8000_0000_0000_0000;

endpackage

@@ src/fnv64_in_if.sv @@
`timescale 1ns / 1ps

interface fnv64_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] data_value;
    logic        start_new;

    modport source (output valid, output kind, output data_value, output start_new,
                    input ready);
    modport sink   (input valid, input kind, input data_value, input start_new,
                    output ready);
endinterface

@@ src/fnv64_out_if.sv @@
`timescale 1ns / 1ps

interface fnv64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_now;

    modport source (output valid, output hash_now, input ready);
    modport sink   (input valid, input hash_now, output ready);
endinterface

@@ src/typed_fnv1a64_hasher_top.sv @@
// an item takes S_RUN once per byte (1, 2, 4 or 8; none for kinds 6, 7), then S_WRITE
// one item at a time via the single xor-multiply unit, one byte a cycle; ready only in S_IDLE
// a new item is accepted while the previous result still waits in the output register
// reset (i_rst_n low, synchronous): hash and seed go to the fnv-1a 64 offset basis, no item held
`timescale 1ns / 1ps

module typed_fnv1a64_hasher_top
    import fnv64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    fnv64_in_if.sink    i_item,
    fnv64_out_if.source o_item
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WRITE} t_state;

    t_state      r_state;
    logic [63:0] r_seed;
    logic [63:0] r_hash;
    logic [63:0] r_data;
    logic [2:0]  r_left;
    logic        r_out_valid;
    logic [63:0] r_out_hash;

    logic        w_accept;
    logic [63:0] n_value;
    logic [3:0]  n_count;
    logic [63:0] w_mix;
    logic [72:0] w_prod;
    logic [63:0] n_step;

    assign i_item.ready = i_rst_n && (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;

    assign o_item.valid    = r_out_valid;
    assign o_item.hash_now = r_out_hash;

    // byte count and value cleanup per kind
    always_comb begin
        n_value = i_item.data_value;
        n_count = 4'd0;
        case (i_item.kind)
            KIND_U8:  n_count = 4'd1;
            KIND_U16: n_count = 4'd2;
            KIND_U32: n_count = 4'd4;
            KIND_U64: n_count = 4'd8;
            KIND_F32: begin
                n_count = 4'd4;
                if (i_item.data_value[31:0] == F32_NEG_ZERO) begin
                    n_value = 64'd0;
                end
            end
            KIND_F64: begin
                n_count = 4'd8;
                if (i_item.data_value == F64_NEG_ZERO) begin
                    n_value = 64'd0;
                end
            end
            default: n_count = 4'd0;
        endcase
    end

    // shared xor-multiply unit: (h ^ b) * (2^40 + 0x1b3) mod 2^64
    assign w_mix  = r_hash ^ {56'd0, r_data[7:0]};
    assign w_prod = {9'd0, w_mix} * {64'd0, FNV_PRIME_LO};
    assign n_step = w_prod[63:0] + {w_mix[63-FNV_PRIME_SHIFT:0], {FNV_PRIME_SHIFT{1'b0}}};

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= FNV_BASIS;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    // sequencer, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= FNV_BASIS;
            r_left      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken; in S_WRITE the write arm decides the flag
            if (r_out_valid && o_item.ready && (r_state != S_WRITE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_item.start_new) begin
                            r_hash <= r_seed;
                        end
                        r_data <= n_value;
                        r_left <= 3'(n_count - 4'd1);
                        r_state <= (n_count == 4'd0) ? S_WRITE : S_RUN;
                    end
                end
                S_RUN: begin
                    r_hash <= n_step;
                    r_data <= {8'd0, r_data[63:8]};
                    r_left <= r_left - 3'd1;
                    if (r_left == 3'd0) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (!r_out_valid || o_item.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_hash  <= r_hash;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/fnv64_chk.sv @@
`timescale 1ns / 1ps
`include "typed_fnv1a64_hasher_top_assert.svh"

module fnv64_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_hash
);

    // a stalled result stays offered
    `FNV64_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")

    // a stalled result keeps its hash
    `FNV64_ASSERT_NEXT(a_hash_hold, i_out_valid && !i_out_ready, $stable(i_out_hash), "hash moved")

    // the block goes busy right after taking an item
    `FNV64_ASSERT_NEXT(a_busy, i_in_valid && i_in_ready, !i_in_ready, "ready after accept")

    // a new result appears only at the end of busy work
    `FNV64_ASSERT_NOW(a_rise, $rose(i_out_valid), !$past(i_in_ready), "result while idle")

endmodule

bind typed_fnv1a64_hasher_top fnv64_chk u_fnv64_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_item.valid),
    .i_out_ready (o_item.ready),
    .i_out_hash  (o_item.hash_now)
);
